@@ hw/rtl/fnpg_pkg.sv @@
// ----------------------------------------------------------------------------
// fnpg_pkg
// Shared types and constants for the prime generator.
// ----------------------------------------------------------------------------
package fnpg_pkg;

   // width of the request count field
   localparam int COUNT_W = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OUT,
      ST_CHECK,
      ST_DIV
   } fnpg_state_type;

   // status returned by the remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } fnpg_div_sts_type;

endpackage

@@ hw/rtl/first_n_primes_generator_top.sv @@
// ----------------------------------------------------------------------------
// first_n_primes_generator_top
// Emits the first N primes in ascending order by trial division, flagging
// the final prime of each run.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  req     | in  | req_valid/req_stall | req_prime_count
//  rsp     | out | rsp_valid/rsp_stall | rsp_prime_value, rsp_last_prime
//
// One request word starts a run; no new request is taken until its last
// response word has been taken. Each trial divisor passes through the
// shared remainder unit (issue, one bit per cycle, result).
// Synchronous active-high reset returns the sequencer to idle.
// A stalled response word holds until taken; the search waits meanwhile.
// ----------------------------------------------------------------------------
module first_n_primes_generator_top #(
   parameter int MAX_COUNT  = 64,
   parameter int PRIME_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fnpg_pkg::COUNT_W-1:0]  req_prime_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [PRIME_BITS-1:0]         rsp_prime_value,
   output logic                          rsp_last_prime
);
   import fnpg_pkg::*;

   // count register width, divisor width (covers sqrt of the candidate + 1)
   localparam int NUM_W = $clog2(MAX_COUNT + 1);
   localparam int DIV_W = (PRIME_BITS + 1) / 2 + 1;
   // candidate and square carry one extra bit to flag overflow
   localparam int CAND_W = PRIME_BITS + 1;

   fnpg_state_type     state_ff, state_in;
   logic [NUM_W-1:0]   want_ff, want_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic [CAND_W-1:0]  sq_ff, sq_in;
   logic [PRIME_BITS-1:0] value_ff, value_in;
   logic               last_ff, last_in;

   logic               div_start;
   fnpg_div_sts_type   div_sts;
   logic [NUM_W-1:0]   want_req;

   // saturate the requested count into 1..MAX_COUNT
   always_comb begin
      if (req_prime_count > COUNT_W'(MAX_COUNT)) begin
         want_req = NUM_W'(MAX_COUNT);
      end else if (req_prime_count == '0) begin
         want_req = NUM_W'(1);
      end else begin
         want_req = NUM_W'(req_prime_count);
      end
   end

   always_comb begin
      state_in  = state_ff;
      want_in   = want_ff;
      num_in    = num_ff;
      cand_in   = cand_ff;
      dvs_in    = dvs_ff;
      sq_in     = sq_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      div_start = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // first word is always 2
               want_in  = want_req;
               num_in   = NUM_W'(1);
               cand_in  = CAND_W'(1);
               value_in = PRIME_BITS'(2);
               last_in  = (want_req == NUM_W'(1));
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cand_in  = cand_ff + CAND_W'(2);
                  dvs_in   = DIV_W'(2);
                  sq_in    = CAND_W'(4);
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (cand_ff[PRIME_BITS]) begin
               // candidate out of range; cannot occur within the count range
               state_in = ST_IDLE;
            end else if (sq_ff > cand_ff) begin
               // no divisor found: prime
               value_in = cand_ff[PRIME_BITS-1:0];
               last_in  = ((num_ff + NUM_W'(1)) == want_ff);
               num_in   = num_ff + NUM_W'(1);
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_sts.done) begin
               if (div_sts.rem_zero) begin
                  // composite: move to next odd candidate
                  cand_in = cand_ff + CAND_W'(2);
                  dvs_in  = DIV_W'(2);
                  sq_in   = CAND_W'(4);
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  dvs_in = dvs_ff + DIV_W'(1);
                  sq_in  = sq_ff + {{(CAND_W - DIV_W - 1){1'b0}}, dvs_ff, 1'b1};
               end
               state_in = ST_CHECK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff  <= want_in;
      num_ff   <= num_in;
      cand_ff  <= cand_in;
      dvs_ff   <= dvs_in;
      sq_ff    <= sq_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   fnpg_rem_unit #(
      .DVD_W (PRIME_BITS),
      .DVS_W (DIV_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff[PRIME_BITS-1:0]),
      .divisor  (dvs_ff),
      .status   (div_sts)
   );

   assign rsp_prime_value = value_ff;
   assign rsp_last_prime  = last_ff;

endmodule

@@ hw/rtl/fnpg_rem_unit.sv @@
// ----------------------------------------------------------------------------
// fnpg_rem_unit
// Restoring radix-2 remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fnpg_rem_unit #(
   parameter int DVD_W = 16,
   parameter int DVS_W = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DVD_W-1:0]             dividend,
   input  logic [DVS_W-1:0]             divisor,
   output fnpg_pkg::fnpg_div_sts_type   status
);
   import fnpg_pkg::*;

   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // trial < 2*divisor, so the restored value fits the divisor width
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for first_n_primes_generator_top. Request words carrying a
// count go in; the primes coming back are checked against an in-bench
// trial-division predictor, word by word, including the flag on the last
// prime. Both channels idle and stall at random until the closing test.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fnpg_pkg::*;

   localparam int MAX_COUNT   = 64;
   localparam int PRIME_BITS  = 16;
   // largest candidate that still fits in a response word
   localparam int PRIME_LIMIT = (1 << PRIME_BITS) - 1;
   // allow plenty of margin over the longest prime gap below 311
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 100;

   typedef struct packed {
      logic [PRIME_BITS-1:0] value;
      logic                  last;
   } prime_word_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [COUNT_W-1:0]   req_prime_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [PRIME_BITS-1:0] rsp_prime_value;
   logic                 rsp_last_prime;

   // primes still owed by the block, oldest first
   prime_word_type expected_primes[$];
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   // random idling on both channels; cleared for the closing back-to-back test
   bit          idling_on = 1'b1;

   first_n_primes_generator_top #(
      .MAX_COUNT  (MAX_COUNT),
      .PRIME_BITS (PRIME_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_prime_count (req_prime_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_last_prime  (rsp_last_prime)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: queues the primes one request word should produce.
   // Count saturates at MAX_COUNT and is raised to at least one; 2 always
   // leads, then odd candidates from 3 by trial division.
   // ------------------------------------------------------------------------
   function automatic void predict_primes(input logic [COUNT_W-1:0] count);
      int unsigned want;
      int unsigned found;
      int unsigned cand;
      int unsigned div;
      bit          composite;
      prime_word_type w;

      want = count;
      if (want > MAX_COUNT) want = MAX_COUNT;
      if (want < 1) want = 1;

      w.value = PRIME_BITS'(2);
      w.last  = (want == 1);
      expected_primes.push_back(w);
      found = 1;
      cand  = 3;
      while (found < want) begin
         // search ran out of width: the last prime so far closes the run
         if (cand > PRIME_LIMIT) begin
            expected_primes[expected_primes.size() - 1].last = 1'b1;
            break;
         end
         composite = 1'b0;
         for (div = 2; div * div <= cand; div++) begin
            if (cand % div == 0) composite = 1'b1;
         end
         if (!composite) begin
            w.value = cand[PRIME_BITS-1:0];
            w.last  = (found + 1 == want);
            expected_primes.push_back(w);
            found++;
         end
         cand += 2;
      end
   endfunction

   task automatic report_mismatch(input string what);
      // cap the printout; every mismatch still counts
      if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; acceptance is seen on
   // the rising edge. Valid stays high between back-to-back words.
   // ------------------------------------------------------------------------
   task automatic send_count(input logic [COUNT_W-1:0] count);
      int unsigned gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_prime_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_primes(count);
   endtask

   // weighted toward short runs
   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7)      return COUNT_W'($urandom_range(0, 15));
      else if (r < 9) return COUNT_W'($urandom_range(16, 63));
      else            return COUNT_W'($urandom_range(64, 127));
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stall bursts between stretches of free running.
   // Off entirely once idling is disabled.
   // ------------------------------------------------------------------------
   int unsigned stall_left = 0;
   int unsigned free_left  = 0;

   always @(negedge clock) begin
      if (!idling_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         free_left = $urandom_range(0, 40);
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Checker: every taken response word against the oldest expected prime.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      prime_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_primes.size() == 0) begin
            report_mismatch($sformatf("unexpected word value=%0d last=%0b",
                                      rsp_prime_value, rsp_last_prime));
         end else begin
            exp_w = expected_primes.pop_front();
            if (rsp_prime_value !== exp_w.value)
               report_mismatch($sformatf("prime_value got %0d want %0d",
                                         rsp_prime_value, exp_w.value));
            if (rsp_last_prime !== exp_w.last)
               report_mismatch($sformatf("last_prime got %0b want %0b (value %0d)",
                                         rsp_last_prime, exp_w.last, exp_w.value));
         end
      end
   end

   // Watchdog: cycles with nothing taken on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL first_n_primes_generator_top");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // zero and one both give the lone word 2 flagged last; two and three
   // check the flag moving along
   task automatic test_short_runs();
      send_count(COUNT_W'(0));
      send_count(COUNT_W'(1));
      send_count(COUNT_W'(2));
      send_count(COUNT_W'(3));
      send_count(COUNT_W'(1));
      send_count(COUNT_W'(5));
   endtask

   // full-length run up to 311, and counts above the cap that saturate;
   // 127 sets every count bit
   task automatic test_saturation();
      send_count(COUNT_W'(MAX_COUNT - 1));
      send_count(COUNT_W'(MAX_COUNT));
      send_count(COUNT_W'(MAX_COUNT + 1));
      send_count(COUNT_W'(127));
      send_count(COUNT_W'(96));
      send_count(COUNT_W'(0));
   endtask

   // random counts under random idling on both sides
   task automatic test_random_counts(input int unsigned n_words);
      repeat (n_words) send_count(pick_count());
   endtask

   // closing stretch: no idling anywhere, words back to back
   task automatic test_back_to_back(input int unsigned n_words);
      idling_on = 1'b0;
      repeat (n_words) send_count(pick_count());
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_short_runs();
      test_saturation();
      test_random_counts(125);
      test_back_to_back(25);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_primes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS first_n_primes_generator_top");
      end else begin
         $display("FAIL first_n_primes_generator_top");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/fnpg_pkg.sv
hw/rtl/fnpg_rem_unit.sv
hw/rtl/first_n_primes_generator_top.sv
verif/tb.sv
